FILE: hw/rtl/twwl_pkg.sv
// ----------------------------------------------------------------------------
// Two-voice wavetable looper package
// Shared types, command codes, register indexes and sizing constants.
// ----------------------------------------------------------------------------
package twwl_pkg;

  // Sizing.
  localparam int LOOP_STEPS_DEFAULT = 64;
  localparam int TABLE_ENTRIES      = 256;
  localparam int TABLE_AW           = $clog2(TABLE_ENTRIES);
  localparam int SAMPLE_W           = 8;
  localparam int VOLUME_W           = 8;
  localparam int PHASE_W            = 16;
  localparam int PITCH_W            = 8;
  localparam int LEVEL_W            = 8;
  localparam int CFG_INDEX_W        = 2;
  localparam int CFG_DATA_W         = 8;

  // Arithmetic constants of the voices and the mixer.
  localparam int NOISE_TOGGLE_BIT = 12;
  localparam int FREQ_SHIFT       = 4;
  // Halving followed by a shift of seven.
  localparam int MIX_SHIFT        = 8;
  localparam int PRODUCT_W        = SAMPLE_W + VOLUME_W;
  localparam int MIX_SUM_W        = PRODUCT_W + 1;
  localparam int MIX_LEVEL_W      = MIX_SUM_W - MIX_SHIFT;
  localparam logic [LEVEL_W-1:0]  LEVEL_MAX    = 8'd255;
  localparam logic [VOLUME_W-1:0] VOLUME_RESET = 8'd255;

  // Command codes.
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_STEP = 2'd1;
  localparam logic [1:0] CMD_LOAD = 2'd2;

  // Result kinds.
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  // Table select codes.
  localparam logic SEL_SINE  = 1'b0;
  localparam logic SEL_NOISE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_VOLUME_A = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_VOLUME_B = 2'd1;

  // Input item.
  typedef struct packed {
    logic [1:0]          command;
    logic [PITCH_W-1:0]  pitch;
    logic                record;
    logic                table_select;
    logic [TABLE_AW-1:0] table_index;
    logic [SAMPLE_W-1:0] table_data;
  } twwl_in_t;

  // Result item.
  typedef struct packed {
    logic               kind;
    logic [LEVEL_W-1:0] pwm_level;
    logic               beat_marker;
  } twwl_out_t;

endpackage

FILE: hw/rtl/twwl_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
module twwl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/two_voice_wavetable_looper_unit.sv
// ----------------------------------------------------------------------------
// Two-voice wavetable looper
// Sine and noise voices mixed to a PWM level, with a pitch loop sequencer.
// ----------------------------------------------------------------------------
// Path: a tick or step result passes the second stage, then the output register.
// Throughput: one item per cycle while the output is taken; the table and
// loop memories each take one access per item, with registered read data.
// Reset: phases, noise index, frequency, loop position and volumes are set.
// The loop store reads as zero until its first full pass; there is no
// clearing pass. Sine and noise tables hold nothing valid until loaded.
module two_voice_wavetable_looper_unit #(
  parameter int LOOP_STEPS = twwl_pkg::LOOP_STEPS_DEFAULT
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  twwl_pkg::twwl_in_t                    in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output twwl_pkg::twwl_out_t                   out_data_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [twwl_pkg::CFG_INDEX_W-1:0]      cfg_index_i,
  input  logic [twwl_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  import twwl_pkg::*;

  localparam int LOOP_AW = $clog2(LOOP_STEPS);
  localparam logic [LOOP_AW-1:0] LOOP_LAST = LOOP_AW'(LOOP_STEPS - 1);

  // Configuration registers.
  logic [VOLUME_W-1:0] volume_a_q, volume_b_q;

  // Voice and sequencer state.
  logic [PHASE_W-1:0]  phase_a_q, phase_a_d;
  logic [PHASE_W-1:0]  phase_b_q, phase_b_d;
  logic [TABLE_AW-1:0] noise_idx_q, noise_idx_d;
  logic [PHASE_W-1:0]  freq_q, freq_eff;
  logic [LOOP_AW-1:0]  loop_pos_q;
  logic                wrapped_q;

  // Second stage.
  logic               s2_valid_q;
  logic               s2_kind_q;
  logic               s2_beat_q;
  logic               s2_from_mem_q;
  logic [PITCH_W-1:0] s2_pitch_q;
  logic               s2_fire;
  logic [PHASE_W-1:0] s2_freq;

  // Output register.
  logic      out_valid_q;
  twwl_out_t out_q, out_d;

  // Handshake and decode.
  logic in_fire, tick_fire, step_fire, load_fire;

  // Memory ports.
  logic                loop_we, loop_re;
  logic [PITCH_W-1:0]  loop_wdata, loop_rdata;
  logic                sine_we, noise_we;
  logic [SAMPLE_W-1:0] sine_rdata, noise_rdata;

  // Mixer.
  logic [PRODUCT_W-1:0]   prod_a, prod_b;
  logic [MIX_SUM_W-1:0]   mix_sum;
  logic [MIX_LEVEL_W-1:0] mix_level;
  logic [LEVEL_W-1:0]     pwm_level;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volume_a_q <= VOLUME_RESET;
      volume_b_q <= VOLUME_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_VOLUME_A: volume_a_q <= cfg_data_i;
        REG_VOLUME_B: volume_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The second stage holds when the output register is full and stalled.
  assign s2_fire    = s2_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s2_valid_q && !s2_fire;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign tick_fire  = in_fire && (in_data_i.command == CMD_TICK);
  assign step_fire  = in_fire && (in_data_i.command == CMD_STEP);
  assign load_fire  = in_fire && (in_data_i.command == CMD_LOAD);

  // Frequency set by a step still in the second stage is forwarded to a tick.
  assign s2_freq  = PHASE_W'({(s2_from_mem_q ? loop_rdata : s2_pitch_q), FREQ_SHIFT'(0)});
  assign freq_eff = (s2_valid_q && (s2_kind_q == KIND_STEP)) ? s2_freq : freq_q;

  // Phase accumulators and the noise index stepping on a toggle of bit 12.
  always_comb begin
    phase_a_d   = phase_a_q + freq_eff;
    phase_b_d   = phase_b_q + freq_eff;
    noise_idx_d = noise_idx_q;
    if (phase_b_d[NOISE_TOGGLE_BIT] != phase_b_q[NOISE_TOGGLE_BIT]) begin
      noise_idx_d = noise_idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_a_q   <= '0;
      phase_b_q   <= '0;
      noise_idx_q <= '0;
    end else if (tick_fire) begin
      phase_a_q   <= phase_a_d;
      phase_b_q   <= phase_b_d;
      noise_idx_q <= noise_idx_d;
    end
  end

  // Before the first wrap a slot is written on every visit, so unvisited
  // slots read as zero without a clearing pass. Afterwards a step without
  // recording reads the slot.
  assign loop_we    = step_fire && (in_data_i.record || !wrapped_q);
  assign loop_re    = step_fire && !in_data_i.record && wrapped_q;
  assign loop_wdata = in_data_i.record ? in_data_i.pitch : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_pos_q <= '0;
      wrapped_q  <= 1'b0;
    end else if (step_fire) begin
      if (loop_pos_q == LOOP_LAST) begin
        loop_pos_q <= '0;
        wrapped_q  <= 1'b1;
      end else begin
        loop_pos_q <= loop_pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q <= '0;
    end else if (s2_fire && (s2_kind_q == KIND_STEP)) begin
      freq_q <= s2_freq;
    end
  end

  twwl_ram #(
    .WIDTH (PITCH_W),
    .DEPTH (LOOP_STEPS)
  ) u_loop_ram (
    .clk_i   (clk_i),
    .we_i    (loop_we),
    .waddr_i (loop_pos_q),
    .wdata_i (loop_wdata),
    .re_i    (loop_re),
    .raddr_i (loop_pos_q),
    .rdata_o (loop_rdata)
  );

  // Table loads and tick reads.
  assign sine_we  = load_fire && (in_data_i.table_select == SEL_SINE);
  assign noise_we = load_fire && (in_data_i.table_select == SEL_NOISE);

  twwl_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_sine_ram (
    .clk_i   (clk_i),
    .we_i    (sine_we),
    .waddr_i (in_data_i.table_index),
    .wdata_i (in_data_i.table_data),
    .re_i    (tick_fire),
    .raddr_i (phase_a_d[PHASE_W-1 -: TABLE_AW]),
    .rdata_o (sine_rdata)
  );

  twwl_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_noise_ram (
    .clk_i   (clk_i),
    .we_i    (noise_we),
    .waddr_i (in_data_i.table_index),
    .wdata_i (in_data_i.table_data),
    .re_i    (tick_fire),
    .raddr_i (noise_idx_d),
    .rdata_o (noise_rdata)
  );

  // Second stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q    <= 1'b0;
      s2_kind_q     <= KIND_TICK;
      s2_beat_q     <= 1'b0;
      s2_from_mem_q <= 1'b0;
    end else if (tick_fire || step_fire) begin
      s2_valid_q    <= 1'b1;
      s2_kind_q     <= step_fire ? KIND_STEP : KIND_TICK;
      s2_beat_q     <= step_fire && (loop_pos_q == '0);
      s2_from_mem_q <= loop_re;
    end else if (s2_fire) begin
      s2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      s2_pitch_q <= loop_wdata;
    end
  end

  // Mixer: products summed without wrap, shifted and saturated.
  always_comb begin
    prod_a    = sine_rdata * volume_a_q;
    prod_b    = noise_rdata * volume_b_q;
    mix_sum   = MIX_SUM_W'(prod_a) + MIX_SUM_W'(prod_b);
    mix_level = mix_sum[MIX_SUM_W-1:MIX_SHIFT];
    pwm_level = (mix_level > MIX_LEVEL_W'(LEVEL_MAX)) ? LEVEL_MAX : mix_level[LEVEL_W-1:0];
  end

  always_comb begin
    out_d.kind        = s2_kind_q;
    out_d.pwm_level   = (s2_kind_q == KIND_TICK) ? pwm_level : '0;
    out_d.beat_marker = s2_beat_q;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The input stalls only while a result waits in the second stage.
  a_stall_needs_s2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s2_valid_q)
    else $error("input stalled with an empty second stage");

  // A result held in the second stage is not dropped.
  a_s2_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && out_valid_q && out_stall_i) |=> s2_valid_q)
    else $error("second stage result lost under stall");

  // A step result carries no level and a tick result no beat.
  a_result_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.kind == KIND_TICK) && !out_data_o.beat_marker) ||
                    ((out_data_o.kind == KIND_STEP) && (out_data_o.pwm_level == '0)))
    else $error("result fields do not match the result kind");

  // The loop position advances by one on each step and wraps at the end.
  a_loop_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fire |=> (loop_pos_q == (($past(loop_pos_q) == LOOP_LAST) ? '0 :
                                  $past(loop_pos_q) + 1'b1)))
    else $error("loop position did not advance correctly");

  // Once the loop store has been fully visited it stays marked.
  a_wrapped_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wrapped_q |=> wrapped_q)
    else $error("loop wrap flag cleared outside reset");

endmodule
